### sv/assert_macros.svh
// Assertion helpers shared by the parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define TLVP_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("tlvp assertion failed");

// Check that a condition never holds outside reset.
`define TLVP_NEVER(lbl, clk_s, rst_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
        else $error("tlvp forbidden condition seen");

`else

`define TLVP_ASSERT(lbl, clk_s, rst_s, prop)
`define TLVP_NEVER(lbl, clk_s, rst_s, cond)

`endif

`endif

### sv/tlvp_pkg.sv
package tlvp_pkg;

    // Value bytes kept per record by default, and the width of the kept registers.
    localparam int VALUE_BYTES_DEF = 4;
    localparam int REG_BYTES       = 4;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;

    // Tag characters
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_C = 8'h43;

    typedef enum logic [3:0] {
        PH_TAG0  = 4'b0001,
        PH_TAG1  = 4'b0010,
        PH_LEN   = 4'b0100,
        PH_VALUE = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        TAG_UNKNOWN = 2'd0,
        TAG_ID      = 2'd1,
        TAG_NM      = 2'd2,
        TAG_SC      = 2'd3
    } tag_t;

    typedef enum logic [1:0] {
        KIND_ID    = 2'd0,
        KIND_NAME  = 2'd1,
        KIND_SCORE = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_CLEAN  = 2'd0,
        ST_HALTED = 2'd1,
        ST_TRUNC  = 2'd2
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] field_value;
        logic [7:0]  name_index;
        logic        record_end;
        logic        buffer_end;
        status_t     end_status;
    } result_t;

    function automatic tag_t decode_tag(input logic [7:0] a, input logic [7:0] b);
        tag_t t;
        t = TAG_UNKNOWN;
        if (a == CH_I && b == CH_D) t = TAG_ID;
        if (a == CH_N && b == CH_M) t = TAG_NM;
        if (a == CH_S && b == CH_C) t = TAG_SC;
        return t;
    endfunction

endpackage

### sv/tlv_record_parser.sv
// Channel  Dir  tdata                                          tuser      tlast
// s_       in   [7:0] data_byte                                -          last_byte
// m_       out  [31:0] field_value, [39:32] name_index,        [1:0] kind buffer_end
//               [40] record_end, [42:41] end_status, pad 0
//
// One byte per clock while the result buffer has room: input register, one
// step of parse logic, two-entry result buffer. Results leave from the buffer.
// s_tready depends only on registered fill state, never on m_tready directly.
// rst_n clears parser state and kept id/score registers asynchronously.
// A stalled output holds the parser once the result buffer is full.
module tlv_record_parser #(
    parameter int VALUE_BYTES = tlvp_pkg::VALUE_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tlvp_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                                s_tlast,   // last_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] field_value, [39:32] name_index, [40] record_end,
    // [42:41] end_status, [47:43] zero
    output logic [tlvp_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [tlvp_pkg::OUT_TUSER_W-1:0]    m_tuser,   // [1:0] kind
    output logic                                m_tlast    // buffer_end
);
    import tlvp_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_last;
    logic       room;
    logic       step;
    logic       have;
    result_t    res;
    result_t    out_res;

    assign step = in_valid && room;

    tlvp_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .take      (step),
        .valid     (in_valid),
        .data_byte (in_byte),
        .last_byte (in_last)
    );

    tlvp_parser #(
        .VALUE_BYTES (VALUE_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte),
        .last_byte (in_last),
        .have      (have),
        .res       (res)
    );

    tlvp_out_fifo u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (step && have),
        .din      (res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dout     (out_res)
    );

    // Pack the result transaction
    assign m_tdata = {5'd0, out_res.end_status, out_res.record_end,
                      out_res.name_index, out_res.field_value};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.buffer_end;

endmodule

### sv/tlvp_in_stage.sv
module tlvp_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    input  logic       take,
    output logic       valid,
    output logic [7:0] data_byte,
    output logic       last_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // Accept a new transaction whenever the held one is empty or leaving now
    assign s_tready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // Capture payload on acceptance
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign valid     = valid_reg;
    assign data_byte = byte_reg;
    assign last_byte = last_reg;

endmodule

### sv/tlvp_parser.sv
`include "assert_macros.svh"

module tlvp_parser #(
    parameter int VALUE_BYTES = tlvp_pkg::VALUE_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              have,
    output tlvp_pkg::result_t res
);
    import tlvp_pkg::*;

    localparam int LIMIT = (VALUE_BYTES < REG_BYTES) ? VALUE_BYTES : REG_BYTES;

    phase_t      phase_reg, phase_next;
    logic [7:0]  first_reg, first_next;
    tag_t        tag_reg, tag_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  pos_reg, pos_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] score_reg, score_next;
    logic        halted_reg, halted_next;
    logic        done;

    // Replace one byte lane of a kept register, ignoring positions past the limit
    function automatic logic [31:0] put_byte(input logic [31:0] r, input logic [7:0] pos,
                                             input logic [7:0] b);
        logic [31:0] o;
        o = r;
        for (int k = 0; k < REG_BYTES; k++)
        begin
            if (k < LIMIT && pos == 8'(k))
            begin
                o[k*8 +: 8] = b;
            end
        end
        return o;
    endfunction

    // Step the parser by one byte
    always_comb
    begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        tag_next    = tag_reg;
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        id_next     = id_reg;
        score_next  = score_reg;
        halted_next = halted_reg;
        done        = 1'b0;
        have        = 1'b0;
        res         = '{kind: KIND_NONE, field_value: 32'd0, name_index: 8'd0,
                        record_end: 1'b0, buffer_end: 1'b0, end_status: ST_CLEAN};

        if (!halted_reg)
        begin
            case (phase_reg)
                PH_TAG0:
                begin
                    first_next = data_byte;
                    phase_next = PH_TAG1;
                end
                PH_TAG1:
                begin
                    tag_next   = decode_tag(first_reg, data_byte);
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if (data_byte == 8'd0)
                    begin
                        halted_next = 1'b1;
                        phase_next  = PH_TAG0;
                    end
                    else
                    begin
                        rem_next   = data_byte;
                        pos_next   = 8'd0;
                        phase_next = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    done = (rem_reg <= 8'd1);
                    case (tag_reg)
                        TAG_ID:
                        begin
                            id_next = put_byte(id_reg, pos_reg, data_byte);
                            if (done)
                            begin
                                have            = 1'b1;
                                res.kind        = KIND_ID;
                                res.field_value = id_next;
                            end
                        end
                        TAG_SC:
                        begin
                            score_next = put_byte(score_reg, pos_reg, data_byte);
                            if (done)
                            begin
                                have            = 1'b1;
                                res.kind        = KIND_SCORE;
                                res.field_value = score_next;
                            end
                        end
                        TAG_NM:
                        begin
                            have            = 1'b1;
                            res.kind        = KIND_NAME;
                            res.field_value = {24'd0, data_byte};
                            res.name_index  = pos_reg;
                        end
                        default:
                        begin
                            have = 1'b0;
                        end
                    endcase
                    if (done)
                    begin
                        res.record_end = 1'b1;
                        rem_next       = 8'd0;
                        phase_next     = PH_TAG0;
                    end
                    else
                    begin
                        rem_next = rem_reg - 8'd1;
                    end
                    pos_next = pos_reg + 8'd1;
                end
                default:
                begin
                    phase_next = PH_TAG0;
                end
            endcase
        end

        // Close the buffer: report status and return to start
        if (last_byte)
        begin
            have           = 1'b1;
            res.buffer_end = 1'b1;
            if (halted_next)
            begin
                res.end_status = ST_HALTED;
            end
            else if (phase_next != PH_TAG0)
            begin
                res.end_status = ST_TRUNC;
            end
            else
            begin
                res.end_status = ST_CLEAN;
            end
            phase_next  = PH_TAG0;
            first_next  = 8'd0;
            tag_next    = TAG_UNKNOWN;
            rem_next    = 8'd0;
            pos_next    = 8'd0;
            halted_next = 1'b0;
        end
    end

    // Advance parser state on each stepped byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TAG0;
            first_reg  <= 8'd0;
            tag_reg    <= TAG_UNKNOWN;
            rem_reg    <= 8'd0;
            pos_reg    <= 8'd0;
            id_reg     <= 32'd0;
            score_reg  <= 32'd0;
            halted_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            tag_reg    <= tag_next;
            rem_reg    <= rem_next;
            pos_reg    <= pos_next;
            id_reg     <= id_next;
            score_reg  <= score_next;
            halted_reg <= halted_next;
        end
    end

    `TLVP_ASSERT(a_phase_onehot, clk, rst_n, $onehot(phase_reg))
    `TLVP_ASSERT(a_halt_at_tag0, clk, rst_n, halted_reg |-> (phase_reg == PH_TAG0))
    `TLVP_ASSERT(a_value_has_bytes, clk, rst_n, (phase_reg == PH_VALUE) |-> (rem_reg != 8'd0))
    `TLVP_ASSERT(a_end_restarts, clk, rst_n,
                 (step && last_byte) |=> (phase_reg == PH_TAG0 && !halted_reg))

endmodule

### sv/tlvp_out_fifo.sv
`include "assert_macros.svh"

module tlvp_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tlvp_pkg::result_t din,
    output logic              room,
    output logic              m_tvalid,
    input  logic              m_tready,
    output tlvp_pkg::result_t dout
);
    import tlvp_pkg::*;

    result_t     mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign room     = (count_reg != 2'd2);
    assign dout     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Hold results until taken
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    `TLVP_NEVER(a_no_overfill, clk, rst_n, count_reg == 2'd3)
    `TLVP_NEVER(a_no_push_full, clk, rst_n, push && count_reg == 2'd2)
    `TLVP_ASSERT(a_drain_last, clk, rst_n,
                 (pop && !push && count_reg == 2'd1) |=> !m_tvalid)

endmodule

### bench/tlv_parse_checker.sv
module tlv_parse_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [tlvp_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                                s_tlast,   // last_byte
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] field_value, [39:32] name_index, [40] record_end,
    // [42:41] end_status, [47:43] zero
    input  logic [tlvp_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic [tlvp_pkg::OUT_TUSER_W-1:0]    m_tuser,   // [1:0] kind
    input  logic                                m_tlast,   // buffer_end
    output int                                  failures,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tlvp_pkg::*;

    // Parser state as seen from the byte stream
    phase_t      ph;
    logic [7:0]  first_tag;
    tag_t        rec_tag;
    logic [7:0]  remaining;
    logic [7:0]  position;
    logic [31:0] id_reg;
    logic [31:0] score_reg;
    logic        halted;

    result_t     expected_fields[$];
    int          mismatch_count;
    int          result_count;

    // Drop a value byte into its little-endian lane; bytes past the kept width are ignored
    function automatic logic [31:0] store_value_byte(input logic [31:0] word,
                                                     input logic [7:0]  pos,
                                                     input logic [7:0]  b);
        if (pos < VALUE_BYTES_DEF && pos < REG_BYTES)
        begin
            word[pos[1:0]*8 +: 8] = b;
        end
        return word;
    endfunction

    task automatic report_mismatch(input string what, input logic [49:0] got,
                                   input logic [49:0] want_val);
        $display("tlv mismatch on result %0d: %s got %0h expected %0h",
                 result_count, what, got, want_val);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t predicted;
        result_t want;
        logic    step_done;
        logic    have;

        if (!rst_n)
        begin
            ph        = PH_TAG0;
            first_tag = '0;
            rec_tag   = TAG_UNKNOWN;
            remaining = '0;
            position  = '0;
            id_reg    = '0;
            score_reg = '0;
            halted    = 1'b0;
            expected_fields.delete();
            mismatch_count = 0;
            result_count   = 0;
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            // Compare each output transaction with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (expected_fields.size() == 0)
                begin
                    report_mismatch("result with nothing expected", {m_tuser, m_tdata}, '0);
                end
                else
                begin
                    want = expected_fields.pop_front();
                    if (m_tuser != want.kind)
                        report_mismatch("kind", 50'(m_tuser), 50'(want.kind));
                    if (m_tdata[31:0] != want.field_value)
                        report_mismatch("field_value", 50'(m_tdata[31:0]),
                                        50'(want.field_value));
                    if (m_tdata[39:32] != want.name_index)
                        report_mismatch("name_index", 50'(m_tdata[39:32]),
                                        50'(want.name_index));
                    if (m_tdata[40] != want.record_end)
                        report_mismatch("record_end", 50'(m_tdata[40]), 50'(want.record_end));
                    if (m_tlast != want.buffer_end)
                        report_mismatch("buffer_end", 50'(m_tlast), 50'(want.buffer_end));
                    if (m_tdata[42:41] != want.end_status)
                        report_mismatch("end_status", 50'(m_tdata[42:41]),
                                        50'(want.end_status));
                    if (m_tdata[47:43] != '0)
                        report_mismatch("tdata padding", 50'(m_tdata[47:43]), '0);
                end
                result_count++;
            end

            // Advance the predicted parser on each input transaction
            if (s_tvalid && s_tready)
            begin
                have = 1'b0;
                predicted.kind        = KIND_NONE;
                predicted.field_value = '0;
                predicted.name_index  = '0;
                predicted.record_end  = 1'b0;
                predicted.buffer_end  = 1'b0;
                predicted.end_status  = ST_CLEAN;

                if (!halted)
                begin
                    case (ph)
                        PH_TAG0:
                        begin
                            first_tag = s_tdata;
                            ph = PH_TAG1;
                        end
                        PH_TAG1:
                        begin
                            case ({first_tag, s_tdata})
                                {CH_I, CH_D}: rec_tag = TAG_ID;
                                {CH_N, CH_M}: rec_tag = TAG_NM;
                                {CH_S, CH_C}: rec_tag = TAG_SC;
                                default:      rec_tag = TAG_UNKNOWN;
                            endcase
                            ph = PH_LEN;
                        end
                        PH_LEN:
                        begin
                            // a zero length halts parsing until the buffer closes
                            if (s_tdata == 8'd0)
                            begin
                                halted = 1'b1;
                                ph = PH_TAG0;
                            end
                            else
                            begin
                                remaining = s_tdata;
                                position  = '0;
                                ph = PH_VALUE;
                            end
                        end
                        default:
                        begin
                            step_done = (remaining <= 8'd1);
                            case (rec_tag)
                                TAG_ID:
                                begin
                                    id_reg = store_value_byte(id_reg, position, s_tdata);
                                    if (step_done)
                                    begin
                                        have = 1'b1;
                                        predicted.kind        = KIND_ID;
                                        predicted.field_value = id_reg;
                                    end
                                end
                                TAG_SC:
                                begin
                                    score_reg = store_value_byte(score_reg, position, s_tdata);
                                    if (step_done)
                                    begin
                                        have = 1'b1;
                                        predicted.kind        = KIND_SCORE;
                                        predicted.field_value = score_reg;
                                    end
                                end
                                TAG_NM:
                                begin
                                    have = 1'b1;
                                    predicted.kind        = KIND_NAME;
                                    predicted.field_value = {24'd0, s_tdata};
                                    predicted.name_index  = position;
                                end
                                default:
                                begin
                                end
                            endcase
                            if (step_done)
                            begin
                                predicted.record_end = 1'b1;
                                remaining = '0;
                                ph = PH_TAG0;
                            end
                            else
                            begin
                                remaining = remaining - 8'd1;
                            end
                            position = position + 8'd1;
                        end
                    endcase
                end

                // Close the buffer: report its status and return to the start
                if (s_tlast)
                begin
                    have = 1'b1;
                    predicted.buffer_end = 1'b1;
                    if (halted)
                        predicted.end_status = ST_HALTED;
                    else if (ph != PH_TAG0)
                        predicted.end_status = ST_TRUNC;
                    else
                        predicted.end_status = ST_CLEAN;
                    ph        = PH_TAG0;
                    first_tag = '0;
                    rec_tag   = TAG_UNKNOWN;
                    remaining = '0;
                    position  = '0;
                    halted    = 1'b0;
                end

                if (have)
                    expected_fields.push_back(predicted);
            end

            failures <= mismatch_count;
            pending  <= expected_fields.size();
        end
    end

endmodule

### bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tlvp_pkg::*;

    localparam int RANDOM_ITEMS = 170;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 10;

    logic                     clk;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_TDATA_W-1:0]    s_tdata  = '0;   // [7:0] data_byte
    logic                     s_tlast  = 1'b0; // last_byte
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // [31:0] field_value, [39:32] name_index, [40] record_end,
    // [42:41] end_status, [47:43] zero
    logic [OUT_TDATA_W-1:0]   m_tdata;
    logic [OUT_TUSER_W-1:0]   m_tuser;         // [1:0] kind
    logic                     m_tlast;         // buffer_end

    int failures;
    int pending;
    int quiet_cycles = 0;
    int sender_idle_pct = 29;
    int recv_stall_pct  = 81;

    // {last_byte, data_byte} for every input transaction, built before driving
    logic [8:0] byte_stream[$];
    logic [7:0] frame_bytes[$];

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    tlv_record_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    tlv_parse_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .failures (failures),
        .pending  (pending)
    );

    // Apply random back-pressure on the result channel
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // End the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Append a record with random value bytes to the buffer being built
    task automatic add_record(input logic [7:0] t0, input logic [7:0] t1, input int len);
        frame_bytes.push_back(t0);
        frame_bytes.push_back(t1);
        frame_bytes.push_back(len[7:0]);
        for (int k = 0; k < len; k++)
        begin
            frame_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    // Move the first keep bytes of the buffer to the stream, last flag on the final one
    task automatic close_frame(input int keep);
        for (int k = 0; k < keep; k++)
        begin
            byte_stream.push_back({(k == keep - 1), frame_bytes[k]});
        end
        frame_bytes.delete();
    endtask

    // One random record; a zero length stops the buffer, with some junk after it
    task automatic add_random_record(output bit stopped);
        int choice;
        int len;

        choice = $urandom_range(99);
        len = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(6, 1);
        stopped = 1'b0;
        if (choice < 30)
            add_record(CH_I, CH_D, len);
        else if (choice < 55)
            add_record(CH_S, CH_C, len);
        else if (choice < 75)
            add_record(CH_N, CH_M, len);
        else if (choice < 85)
            add_record(8'($urandom_range(255)), 8'($urandom_range(255)), len);
        else if (choice < 90)
            add_record(CH_I, CH_C, len);
        else
        begin
            case ($urandom_range(2))
                0:       add_record(CH_I, CH_D, 0);
                1:       add_record(CH_N, CH_M, 0);
                default: add_record(8'($urandom_range(255)), 8'($urandom_range(255)), 0);
            endcase
            repeat ($urandom_range(3))
                frame_bytes.push_back(8'($urandom_range(255)));
            stopped = 1'b1;
        end
    endtask

    initial
    begin : stimulus
        int  random_start;
        int  total;
        int  style;
        int  nrec;
        bit  stopped;

        // Directed buffers
        // a lone last byte leaves the tag incomplete
        frame_bytes = '{8'hFF};
        close_frame(1);
        // ID with a fifth value byte that must be ignored, ending on the last byte
        frame_bytes = '{CH_I, CH_D, 8'd5, 8'h00, 8'hFF, 8'h12, 8'h34, 8'hAB};
        close_frame(frame_bytes.size());
        // name byte, then an unknown record whose end closes the buffer
        frame_bytes = '{CH_N, CH_M, 8'd1, 8'hFF, 8'h5A, 8'h5A, 8'd1, 8'h00};
        close_frame(frame_bytes.size());
        // zero length on the last byte
        frame_bytes = '{CH_S, CH_C, 8'd0};
        close_frame(frame_bytes.size());
        // score value cut short, keeping the byte already received
        frame_bytes = '{CH_S, CH_C, 8'd2, 8'h01};
        close_frame(frame_bytes.size());
        // buffer ending before the length byte
        frame_bytes = '{CH_S, CH_C};
        close_frame(frame_bytes.size());

        // Longest name record: positions run up to 254
        add_record(CH_N, CH_M, 255);
        close_frame(frame_bytes.size());

        // Random buffers: mostly well-formed, some truncated, a few pure noise
        random_start = byte_stream.size();
        while (byte_stream.size() < random_start + RANDOM_ITEMS)
        begin
            style = $urandom_range(99);
            if (style < 5)
            begin
                repeat ($urandom_range(8, 1))
                    frame_bytes.push_back(8'($urandom_range(255)));
                close_frame(frame_bytes.size());
            end
            else
            begin
                nrec = $urandom_range(4, 1);
                stopped = 1'b0;
                for (int r = 0; r < nrec && !stopped; r++)
                begin
                    add_random_record(stopped);
                end
                if (style < 82)
                    close_frame(frame_bytes.size());
                else
                    close_frame($urandom_range(frame_bytes.size() - 1, 1));
            end
        end

        // Hold reset, then release
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Drive the stream, changing idle pattern every third of the way
        total = byte_stream.size();
        for (int i = 0; i < total; i++)
        begin
            if (i * 3 < total)
            begin
                sender_idle_pct = 29;
                recv_stall_pct  = 81;
            end
            else if (i * 3 < total * 2)
            begin
                sender_idle_pct = 81;
                recv_stall_pct  = 29;
            end
            else
            begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end
            while ($urandom_range(99) < sender_idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= byte_stream[i][7:0];
            s_tlast  <= byte_stream[i][8];
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then allow for the pipeline latency
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/tlvp_pkg.sv
sv/tlvp_in_stage.sv
sv/tlvp_parser.sv
sv/tlvp_out_fifo.sv
sv/tlv_record_parser.sv
bench/tlv_parse_checker.sv
bench/testbench.sv
